/* design/hlpg_pkg.sv */
`timescale 1ns / 1ps

package hlpg_pkg;

  // Defaults for the top-level parameters.
  localparam int ANGLE_COUNT_DEF = 180;
  localparam int RHO_SCALE_DEF   = 2;
  localparam int COORD_BITS_DEF  = 10;

  // Trig values are signed Q2.14.
  localparam int Q_FRAC_BITS = 14;

  localparam logic [10:0] WIDTH_RESET  = 11'd720;
  localparam logic [10:0] HEIGHT_RESET = 11'd540;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // round(sin(d) * 16384) for d = 0..90.
  localparam logic [14:0] SINE_QUARTER [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16361, 15'd16374, 15'd16382, 15'd16384
  };

  // Item context that travels alongside the division.
  typedef struct packed {
    logic       ok;    // line and position are valid, divisor nonzero
    logic       rows;  // position is a row
    logic       neg;   // quotient is negative
    logic       fin;
    logic [9:0] pos;
  } hlpg_side_t;

  // Q2.14 sine of a whole degree in 0..359, folded onto the quarter table.
  function automatic logic signed [15:0] sine_q(input logic [8:0] deg);
    logic [8:0]  t;
    logic        neg;
    logic [14:0] v;
    if (deg <= 9'd90) begin
      t   = deg;
      neg = 1'b0;
    end else if (deg <= 9'd180) begin
      t   = 9'd180 - deg;
      neg = 1'b0;
    end else if (deg <= 9'd270) begin
      t   = deg - 9'd180;
      neg = 1'b1;
    end else begin
      t   = 9'd360 - deg;
      neg = 1'b1;
    end
    v = SINE_QUARTER[t[6:0]];
    sine_q = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

/* design/hlpg_front.sv */
`timescale 1ns / 1ps

module hlpg_front #(
  parameter int ANGLE_COUNT = hlpg_pkg::ANGLE_COUNT_DEF,
  parameter int RHO_SCALE   = hlpg_pkg::RHO_SCALE_DEF,
  parameter int COORD_BITS  = hlpg_pkg::COORD_BITS_DEF,
  parameter int MAG_BITS    = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [10:0]      line_distance,
  input  logic [7:0]              line_angle,
  input  logic [9:0]              sweep_position,
  input  logic                    final_item,
  input  logic [10:0]             image_width,
  input  logic [10:0]             image_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [MAG_BITS-1:0]     num_mag,
  output logic [14:0]             div_mag,
  output hlpg_pkg::hlpg_side_t    side
);
  import hlpg_pkg::*;

  localparam int          NUM_W     = MAG_BITS + 1;
  localparam int          SCALE_Q   = RHO_SCALE * (1 << Q_FRAC_BITS);
  localparam logic [8:0]  ANGLE_LIM = 9'(ANGLE_COUNT);
  localparam logic [8:0]  QUARTER   = 9'(ANGLE_COUNT / 4);
  localparam logic [8:0]  THREE_Q   = 9'(3 * ANGLE_COUNT / 4);
  localparam logic [12:0] COORD_LIM = 13'(1 << COORD_BITS);

  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // Stage 1: input register.
  logic               s1_valid_r;
  logic signed [10:0] rho1_r;
  logic [7:0]         angle1_r;
  logic [9:0]         pos1_r;
  logic               fin1_r;

  // Stage 2: trig lookup and centering.
  logic               s2_valid_r;
  logic signed [11:0] c2_r;
  logic signed [15:0] tk2_r;
  logic signed [15:0] ts2_r;
  logic signed [10:0] rho2_r;
  hlpg_side_t         side2_r;

  // Stage 3: numerator.
  logic                    s3_valid_r;
  logic signed [NUM_W-1:0] num3_r;
  logic signed [15:0]      ts3_r;
  hlpg_side_t              side3_r;

  // Stage 4: magnitudes and quotient sign.
  logic                s4_valid_r;
  logic [MAG_BITS-1:0] mag4_r;
  logic [14:0]         div4_r;
  hlpg_side_t          side4_r;

  assign s4_ready = !s4_valid_r || out_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 2 logic.
  logic               rows_nxt;
  logic               angle_ok;
  logic               pos_ok;
  logic signed [15:0] sn;
  logic signed [15:0] cs;
  logic [10:0]        dim_k;
  logic signed [11:0] c_nxt;
  logic signed [15:0] tk_nxt;
  logic signed [15:0] ts_nxt;
  hlpg_side_t         side2_nxt;

  always_comb begin
    rows_nxt = ({1'b0, angle1_r} < QUARTER) || ({1'b0, angle1_r} >= THREE_Q);
    angle_ok = {1'b0, angle1_r} < ANGLE_LIM;
    sn       = sine_q({1'b0, angle1_r});
    cs       = sine_q({1'b0, angle1_r} + 9'd90);
    dim_k    = rows_nxt ? image_height : image_width;
    c_nxt    = $signed({2'b00, pos1_r}) - $signed({2'b00, dim_k[10:1]});
    tk_nxt   = rows_nxt ? sn : cs;
    ts_nxt   = rows_nxt ? cs : sn;
    pos_ok   = ({1'b0, pos1_r} < dim_k) && ({3'b000, pos1_r} < COORD_LIM);
    side2_nxt.ok   = angle_ok && pos_ok && (ts_nxt != 16'sd0);
    side2_nxt.rows = rows_nxt;
    side2_nxt.neg  = 1'b0;
    side2_nxt.fin  = fin1_r;
    side2_nxt.pos  = pos1_r;
  end

  // Stage 3 logic: rho*RHO_SCALE*16384 - c_known*trig_known.
  logic signed [27:0]      prod;
  logic signed [NUM_W-1:0] scaled;
  logic signed [NUM_W-1:0] num_nxt;

  assign prod    = c2_r * tk2_r;
  assign scaled  = NUM_W'(rho2_r) * NUM_W'(SCALE_Q);
  assign num_nxt = scaled - NUM_W'(prod);

  // Stage 4 logic.
  logic [NUM_W-1:0] num_abs;
  logic [15:0]      ts_abs;
  hlpg_side_t       side4_nxt;

  always_comb begin
    num_abs = num3_r[NUM_W-1] ? NUM_W'(-num3_r) : NUM_W'(num3_r);
    ts_abs  = ts3_r[15] ? 16'(-ts3_r) : 16'(ts3_r);
    side4_nxt     = side3_r;
    side4_nxt.neg = num3_r[NUM_W-1] ^ ts3_r[15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      rho1_r   <= line_distance;
      angle1_r <= line_angle;
      pos1_r   <= sweep_position;
      fin1_r   <= final_item;
    end
    if (s2_ready && s1_valid_r) begin
      c2_r    <= c_nxt;
      tk2_r   <= tk_nxt;
      ts2_r   <= ts_nxt;
      rho2_r  <= rho1_r;
      side2_r <= side2_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      num3_r  <= num_nxt;
      ts3_r   <= ts2_r;
      side3_r <= side2_r;
    end
    if (s4_ready && s3_valid_r) begin
      mag4_r  <= num_abs[MAG_BITS-1:0];
      div4_r  <= ts_abs[14:0];
      side4_r <= side4_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign num_mag   = mag4_r;
  assign div_mag   = div4_r;
  assign side      = side4_r;

endmodule

/* design/hlpg_div_cell.sv */
`timescale 1ns / 1ps

module hlpg_div_cell #(
  parameter int MAG_BITS = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAG_BITS-1:0]  in_quo,
  input  logic [14:0]          in_rem,
  input  logic [14:0]          in_div,
  input  hlpg_pkg::hlpg_side_t in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MAG_BITS-1:0]  out_quo,
  output logic [14:0]          out_rem,
  output logic [14:0]          out_div,
  output hlpg_pkg::hlpg_side_t out_side
);
  import hlpg_pkg::*;

  logic                valid_r;
  logic [MAG_BITS-1:0] quo_r;
  logic [14:0]         rem_r;
  logic [14:0]         div_r;
  hlpg_side_t          side_r;

  // One restoring step: the dividend word shifts out at the top while the
  // quotient bit enters at the bottom of the same word.
  logic [15:0]         trial;
  logic                ge;
  logic [15:0]         diff;
  logic [MAG_BITS-1:0] quo_nxt;
  logic [14:0]         rem_nxt;

  always_comb begin
    trial   = {in_rem, in_quo[MAG_BITS-1]};
    ge      = trial >= {1'b0, in_div};
    diff    = trial - {1'b0, in_div};
    rem_nxt = ge ? diff[14:0] : trial[14:0];
    quo_nxt = {in_quo[MAG_BITS-2:0], ge};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      div_r  <= in_div;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_quo   = quo_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

/* design/hlpg_back.sv */
`timescale 1ns / 1ps

module hlpg_back #(
  parameter int COORD_BITS = hlpg_pkg::COORD_BITS_DEF,
  parameter int MAG_BITS   = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAG_BITS-1:0]  quotient,
  input  hlpg_pkg::hlpg_side_t side,
  input  logic [10:0]          image_width,
  input  logic [10:0]          image_height,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [9:0]           point_x,
  output logic [9:0]           point_y,
  output logic [19:0]          pixel_address,
  output logic                 swept_rows,
  output logic                 final_result
);
  import hlpg_pkg::*;

  localparam int          SW        = MAG_BITS + 2;
  localparam logic [12:0] COORD_LIM = 13'(1 << COORD_BITS);

  logic b1_ready, b2_ready;

  // Stage 1: signed quotient, offset back to the corner origin, bounds.
  logic        v1_r;
  logic        hit1_r;
  logic [10:0] x1_r;
  logic [10:0] y1_r;
  logic        rows1_r;
  logic        fin1_r;

  // Stage 2: address and output register.
  logic        v2_r;
  logic        hit2_r;
  logic [10:0] x2_r;
  logic [10:0] y2_r;
  logic [19:0] addr2_r;
  logic        rows2_r;
  logic        fin2_r;

  logic signed [SW-1:0] q_ext;
  logic signed [SW-1:0] solved;
  logic [10:0]          dim_s;
  logic                 hit1_nxt;
  logic [10:0]          pos11;
  logic [10:0]          x1_nxt;
  logic [10:0]          y1_nxt;

  always_comb begin
    dim_s    = side.rows ? image_width : image_height;
    q_ext    = $signed({2'b00, quotient});
    solved   = (side.neg ? -q_ext : q_ext) + $signed(SW'(dim_s[10:1]));
    hit1_nxt = side.ok && !solved[SW-1]
               && (solved < $signed(SW'(dim_s)))
               && (solved < $signed(SW'(COORD_LIM)));
    pos11    = {1'b0, side.pos};
    x1_nxt   = 11'd0;
    y1_nxt   = 11'd0;
    if (hit1_nxt) begin
      x1_nxt = side.rows ? solved[10:0] : pos11;
      y1_nxt = side.rows ? pos11 : solved[10:0];
    end
  end

  logic [21:0] addr_full;
  assign addr_full = 22'(y1_r) * 22'(image_width) + 22'(x1_r);

  assign b2_ready = !v2_r || out_ready;
  assign b1_ready = !v1_r || b2_ready;
  assign in_ready = b1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (b1_ready) v1_r <= in_valid;
      if (b2_ready) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready && in_valid) begin
      hit1_r  <= hit1_nxt;
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      rows1_r <= side.rows;
      fin1_r  <= side.fin;
    end
    if (b2_ready && v1_r) begin
      hit2_r  <= hit1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      addr2_r <= addr_full[19:0];
      rows2_r <= rows1_r;
      fin2_r  <= fin1_r;
    end
  end

  assign out_valid     = v2_r;
  assign hit           = hit2_r;
  assign point_x       = x2_r[9:0];
  assign point_y       = y2_r[9:0];
  assign pixel_address = addr2_r;
  assign swept_rows    = rows2_r;
  assign final_result  = fin2_r;

endmodule

/* design/hough_line_point_generator_unit.sv */
`timescale 1ns / 1ps

// Hough line point generator. Each input transfer carries one line (rho,
// theta in whole degrees) and a sweep position; the block returns the one
// pixel the line crosses there, with a hit flag, the coordinates and the
// address y*image_width+x. Near-vertical lines sweep rows and solve for the
// column, the others sweep columns and solve for the row. One item is taken
// per clock and one result leaves per clock while out_tready is high. The
// pipeline is four front stages (input, trig lookup, numerator multiply,
// magnitudes), a row of divider cells, each of which resolves one quotient
// bit, and two back stages (bounds check, address multiply into the output
// register). Every stage holds its own item, so the pipeline keeps accepting
// while a result waits as long as a stage is free. image_width and
// image_height may only be changed while no item is in flight.
module hough_line_point_generator_unit #(
  parameter int ANGLE_COUNT = hlpg_pkg::ANGLE_COUNT_DEF,
  parameter int RHO_SCALE   = hlpg_pkg::RHO_SCALE_DEF,
  parameter int COORD_BITS  = hlpg_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // line_distance, line_angle, sweep_position, zero fill
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // point_x, point_y, pixel_address
  output logic [1:0]  out_tuser,  // hit, swept_rows
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);
  import hlpg_pkg::*;

  // Magnitude bound of the numerator; the quotient never exceeds it.
  localparam int MAG_BITS = $clog2((1024 * RHO_SCALE + 1024) * (1 << Q_FRAC_BITS));
  localparam int CELLS    = MAG_BITS;

  logic [10:0] image_width_r;
  logic [10:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic                valid_c [CELLS+1];
  logic                ready_c [CELLS+1];
  logic [MAG_BITS-1:0] quo_c   [CELLS+1];
  logic [14:0]         rem_c   [CELLS+1];
  logic [14:0]         div_c   [CELLS+1];
  hlpg_side_t          side_c  [CELLS+1];

  hlpg_front #(
    .ANGLE_COUNT (ANGLE_COUNT),
    .RHO_SCALE   (RHO_SCALE),
    .COORD_BITS  (COORD_BITS),
    .MAG_BITS    (MAG_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .line_distance  ($signed(in_tdata[10:0])),
    .line_angle     (in_tdata[18:11]),
    .sweep_position (in_tdata[28:19]),
    .final_item     (in_tlast),
    .image_width    (image_width_r),
    .image_height   (image_height_r),
    .out_valid      (valid_c[0]),
    .out_ready      (ready_c[0]),
    .num_mag        (quo_c[0]),
    .div_mag        (div_c[0]),
    .side           (side_c[0])
  );

  assign rem_c[0] = 15'd0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    hlpg_div_cell #(
      .MAG_BITS (MAG_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_c[k]),
      .in_ready  (ready_c[k]),
      .in_quo    (quo_c[k]),
      .in_rem    (rem_c[k]),
      .in_div    (div_c[k]),
      .in_side   (side_c[k]),
      .out_valid (valid_c[k+1]),
      .out_ready (ready_c[k+1]),
      .out_quo   (quo_c[k+1]),
      .out_rem   (rem_c[k+1]),
      .out_div   (div_c[k+1]),
      .out_side  (side_c[k+1])
    );
  end

  logic        hit;
  logic [9:0]  point_x;
  logic [9:0]  point_y;
  logic [19:0] pixel_address;
  logic        swept_rows;
  logic        final_result;

  hlpg_back #(
    .COORD_BITS (COORD_BITS),
    .MAG_BITS   (MAG_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (valid_c[CELLS]),
    .in_ready      (ready_c[CELLS]),
    .quotient      (quo_c[CELLS]),
    .side          (side_c[CELLS]),
    .image_width   (image_width_r),
    .image_height  (image_height_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .hit           (hit),
    .point_x       (point_x),
    .point_y       (point_y),
    .pixel_address (pixel_address),
    .swept_rows    (swept_rows),
    .final_result  (final_result)
  );

  // The final remainder and divisor are not needed past the last cell.
  logic unused_tail;
  assign unused_tail = ^{rem_c[CELLS], div_c[CELLS], in_tdata[31:29]};

  assign out_tdata = {pixel_address, point_y, point_x};
  assign out_tuser = {swept_rows, hit & ~unused_tail | hit & unused_tail};
  assign out_tlast = final_result;

endmodule
